[rtl/rie_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rie_pkg;

  // Storage geometry. MEM_DEPTH is a power of two; addresses wrap on its low bits.
  localparam int unsigned MEM_DEPTH = 4096;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
  localparam int unsigned NUM_REGS  = 16;
  localparam int unsigned RF_AW     = $clog2(NUM_REGS);

  localparam int unsigned XLEN   = 32;
  localparam int unsigned WORD_W = 20;
  localparam int unsigned PC_W   = 12;
  localparam int unsigned LA_W   = 12;
  localparam int unsigned PLEN_W = 13;
  localparam int unsigned OP_W   = 8;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_PROGRAM_LENGTH = 1'b0;
  localparam logic [PLEN_W-1:0] PLEN_RESET = 13'h1000;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ADD  = 8'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 8'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 8'd2;
  localparam logic [OP_W-1:0] OP_AND  = 8'd3;
  localparam logic [OP_W-1:0] OP_OR   = 8'd4;
  localparam logic [OP_W-1:0] OP_XOR  = 8'd5;
  localparam logic [OP_W-1:0] OP_SLL  = 8'd6;
  localparam logic [OP_W-1:0] OP_SRA  = 8'd7;
  localparam logic [OP_W-1:0] OP_SRL  = 8'd8;
  localparam logic [OP_W-1:0] OP_BEQ  = 8'd9;
  localparam logic [OP_W-1:0] OP_BNE  = 8'd10;
  localparam logic [OP_W-1:0] OP_BLT  = 8'd11;
  localparam logic [OP_W-1:0] OP_BGT  = 8'd12;
  localparam logic [OP_W-1:0] OP_BLE  = 8'd13;
  localparam logic [OP_W-1:0] OP_BGE  = 8'd14;
  localparam logic [OP_W-1:0] OP_JAL  = 8'd15;
  localparam logic [OP_W-1:0] OP_LW   = 8'd16;
  localparam logic [OP_W-1:0] OP_SW   = 8'd17;
  localparam logic [OP_W-1:0] OP_RETI = 8'd18;
  localparam logic [OP_W-1:0] OP_IN   = 8'd19;
  localparam logic [OP_W-1:0] OP_OUT  = 8'd20;
  localparam logic [OP_W-1:0] OP_HALT = 8'd21;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic decode;
    logic get_rs;
    logic get_rt;
    logic get_rd;
    logic exec;
    logic wb;
    logic load_out;
  } rie_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic exec_go;
  } rie_sts_t;

  function automatic logic [MEM_AW-1:0] mem_addr(input logic [XLEN-1:0] a);
    return a[MEM_AW-1:0];
  endfunction

  function automatic logic [PC_W-1:0] pc_wrap(input logic [XLEN-1:0] a);
    logic [XLEN-1:0] w;
    w = XLEN'(mem_addr(a));
    return w[PC_W-1:0];
  endfunction

  function automatic logic [XLEN-1:0] sext_word(input logic [WORD_W-1:0] w);
    return {{(XLEN-WORD_W){w[WORD_W-1]}}, w};
  endfunction

endpackage

`default_nettype wire

[rtl/risc_instruction_execute.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sixteen-register processor core with 20-bit memory words and 32-bit registers.
// Each input word is one action: a load (action 0) writes load_data into the
// shared instruction/data memory, an execute (action 1) runs the instruction at
// the program counter. Every accepted word yields exactly one result word that
// reports the executed pc, the fetched instruction, the next pc, the halt state,
// any register write, the running cycle count and an unsupported-opcode flag.
// After reset the block sweeps memory and register file to zero, one entry per
// clock, so in_ready_o stays low until all MEM_DEPTH memory entries are cleared;
// program_length may be written over the APB port during that sweep.
// An execute goes from acceptance to a loaded result through fetch, immediate
// read and three register reads through the single-read-port register file,
// execute with the data access, and write back. A load, or an execute while
// halted, goes straight to the result. One word is in flight at a time; a
// finished result sits in the output register while the next word is taken.
// Write program_length only while no word is in flight; nothing enforces it.

module risc_instruction_execute
  import rie_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input words
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                action_i,
  input  wire logic [LA_W-1:0]     load_address_i,
  input  wire logic [WORD_W-1:0]   load_data_i,
  // result words
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [PC_W-1:0]     exec_pc_o,
  output logic      [WORD_W-1:0]   instruction_word_o,
  output logic      [PC_W-1:0]     next_pc_o,
  output logic                     halted_o,
  output logic                     reg_write_o,
  output logic      [RF_AW-1:0]    reg_index_o,
  output logic signed [XLEN-1:0]   reg_value_o,
  output logic      [XLEN-1:0]     cycle_count_o,
  output logic                     unsupported_o,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready
);

  rie_cmd_t          cmd;
  rie_sts_t          sts;
  logic [PLEN_W-1:0] plen_q;
  logic              cfg_we;
  logic              hit_plen;

  // Register select uses the word index; byte lanes within a word are ignored.
  assign hit_plen = (paddr[APB_AW-1:2] == REG_PROGRAM_LENGTH);
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && pready && hit_plen;
  assign prdata   = hit_plen ? APB_DW'(plen_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= PLEN_RESET;
    end else if (cfg_we) begin
      plen_q <= pwdata[PLEN_W-1:0];
    end
  end

  // Sequencer: steps each word through fetch, operand, execute and write back.
  rie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Memory, register file, ALU, pc and the output register.
  rie_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .action_i           (action_i),
    .load_address_i     (load_address_i),
    .load_data_i        (load_data_i),
    .prog_len_i         (plen_q),
    .exec_pc_o          (exec_pc_o),
    .instruction_word_o (instruction_word_o),
    .next_pc_o          (next_pc_o),
    .halted_o           (halted_o),
    .reg_write_o        (reg_write_o),
    .reg_index_o        (reg_index_o),
    .reg_value_o        (reg_value_o),
    .cycle_count_o      (cycle_count_o),
    .unsupported_o      (unsupported_o)
  );

endmodule

`default_nettype wire

[rtl/rie_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module rie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/rie_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module rie_ctrl
  import rie_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire rie_sts_t sts_i,
  output rie_cmd_t      cmd_o
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_FETCH  = 10'b00_0000_0100,
    S_DECODE = 10'b00_0000_1000,
    S_RS     = 10'b00_0001_0000,
    S_RT     = 10'b00_0010_0000,
    S_RD     = 10'b00_0100_0000,
    S_EXEC   = 10'b00_1000_0000,
    S_WB     = 10'b01_0000_0000,
    S_RESP   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.exec_go ? S_FETCH : S_RESP;
        end
      end
      S_FETCH:  state_d = S_DECODE;
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = S_RS;
      end
      S_RS: begin
        cmd_o.get_rs = 1'b1;
        state_d      = S_RT;
      end
      S_RT: begin
        cmd_o.get_rt = 1'b1;
        state_d      = S_RD;
      end
      S_RD: begin
        cmd_o.get_rd = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_WB;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/rie_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module rie_datapath
  import rie_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rie_cmd_t            cmd_i,
  output rie_sts_t                 sts_o,
  input  wire logic                action_i,
  input  wire logic [LA_W-1:0]     load_address_i,
  input  wire logic [WORD_W-1:0]   load_data_i,
  input  wire logic [PLEN_W-1:0]   prog_len_i,
  output logic      [PC_W-1:0]     exec_pc_o,
  output logic      [WORD_W-1:0]   instruction_word_o,
  output logic      [PC_W-1:0]     next_pc_o,
  output logic                     halted_o,
  output logic                     reg_write_o,
  output logic      [RF_AW-1:0]    reg_index_o,
  output logic signed [XLEN-1:0]   reg_value_o,
  output logic      [XLEN-1:0]     cycle_count_o,
  output logic                     unsupported_o
);

  function automatic logic [XLEN-1:0] reg_sel(input logic [RF_AW-1:0] idx,
                                              input logic [XLEN-1:0]  raw,
                                              input logic [XLEN-1:0]  imm);
    logic [XLEN-1:0] v;
    if (idx == RF_AW'(0)) begin
      v = '0;
    end else if (idx == RF_AW'(1)) begin
      v = imm;
    end else begin
      v = raw;
    end
    return v;
  endfunction

  // Architectural state
  logic [PC_W-1:0]   pc_q;
  logic              halt_q;
  logic [XLEN-1:0]   cyc_q;
  logic [MEM_AW-1:0] clr_q;

  // Per-instruction working registers
  logic [PC_W-1:0]   exec_pc_q;
  logic [WORD_W-1:0] ir_q;
  logic [XLEN-1:0]   imm_q, a_q, b_q, c_q, res_q;
  logic [PC_W-1:0]   npc_q;
  logic              wr_q, unsup_q;
  logic [RF_AW-1:0]  widx_q;
  logic [XLEN-1:0]   wval_q;

  // Output register
  logic [PC_W-1:0]   o_exec_pc_q, o_next_pc_q;
  logic [WORD_W-1:0] o_iw_q;
  logic              o_halted_q, o_wr_q, o_unsup_q;
  logic [RF_AW-1:0]  o_idx_q;
  logic [XLEN-1:0]   o_val_q, o_cyc_q;

  // Memory and register file ports
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;
  logic              rf_we;
  logic [RF_AW-1:0]  rf_waddr, rf_raddr;
  logic [XLEN-1:0]   rf_wdata, rf_rdata;

  logic [OP_W-1:0]   op;
  logic [RF_AW-1:0]  rd, rs, rt;
  logic              long_f, ls_f, dst_f, taken;
  logic [XLEN-1:0]   pc_ext, seq_pc, addr_sum, imm_d, alu_res, target, res_fin;
  logic [1:0]        cyc_inc;
  logic              halted_now, rf_wr;

  assign op = ir_q[WORD_W-1:12];
  assign rd = ir_q[11:8];
  assign rs = ir_q[7:4];
  assign rt = ir_q[3:0];

  assign pc_ext   = XLEN'(pc_q);
  assign addr_sum = a_q + b_q;
  assign seq_pc   = pc_ext + (long_f ? XLEN'(2) : XLEN'(1));

  always_comb begin
    if (op inside {[OP_ADD:OP_SRL], OP_LW, OP_IN}) begin
      long_f = (rs == RF_AW'(1)) || (rt == RF_AW'(1));
    end else if (op inside {[OP_BEQ:OP_BGE], OP_SW, OP_OUT}) begin
      long_f = (rs == RF_AW'(1)) || (rt == RF_AW'(1)) || (rd == RF_AW'(1));
    end else if (op == OP_JAL) begin
      long_f = (rs == RF_AW'(1));
    end else begin
      long_f = 1'b0;
    end
  end

  assign ls_f    = (op == OP_LW) || (op == OP_SW);
  assign dst_f   = (op inside {[OP_ADD:OP_SRL], OP_JAL, OP_LW});
  assign cyc_inc = 2'd1 + {1'b0, long_f} + {1'b0, ls_f};
  assign imm_d   = long_f ? sext_word(mem_rdata) : '0;

  // ALU
  always_comb begin
    case (op)
      OP_ADD:  alu_res = a_q + b_q;
      OP_SUB:  alu_res = a_q - b_q;
      OP_MUL:  alu_res = a_q * b_q;
      OP_AND:  alu_res = a_q & b_q;
      OP_OR:   alu_res = a_q | b_q;
      OP_XOR:  alu_res = a_q ^ b_q;
      OP_SLL:  alu_res = a_q << b_q[4:0];
      OP_SRA:  alu_res = XLEN'($signed(a_q) >>> b_q[4:0]);
      OP_SRL:  alu_res = a_q >> b_q[4:0];
      OP_JAL:  alu_res = seq_pc;
      default: alu_res = '0;
    endcase
  end

  // Branch decision and next pc
  always_comb begin
    case (op)
      OP_BEQ:  taken = (a_q == b_q);
      OP_BNE:  taken = (a_q != b_q);
      OP_BLT:  taken = ($signed(a_q) < $signed(b_q));
      OP_BGT:  taken = ($signed(b_q) < $signed(a_q));
      OP_BLE:  taken = !($signed(b_q) < $signed(a_q));
      OP_BGE:  taken = !($signed(a_q) < $signed(b_q));
      default: taken = 1'b0;
    endcase
    if (op == OP_HALT) begin
      target = pc_ext;
    end else if (op == OP_JAL) begin
      // a link into the jump register itself wins over the old value
      target = ((rs == rd) && (rd >= RF_AW'(2))) ? seq_pc : a_q;
    end else if (taken) begin
      target = c_q;
    end else begin
      target = seq_pc;
    end
  end

  assign res_fin    = (op == OP_LW) ? sext_word(mem_rdata) : res_q;
  assign rf_wr      = cmd_i.wb && dst_f && (rd >= RF_AW'(2));
  assign halted_now = halt_q || ({1'b0, pc_q} >= prog_len_i);

  assign sts_o.clr_last = (clr_q == MEM_AW'(MEM_DEPTH - 1));
  assign sts_o.exec_go  = action_i && !halted_now;

  // Memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_raddr = mem_addr(pc_ext);
    if (cmd_i.clear) begin
      mem_we = 1'b1;
    end else if (cmd_i.accept && !action_i) begin
      mem_we    = 1'b1;
      mem_waddr = mem_addr(XLEN'(load_address_i));
      mem_wdata = load_data_i;
    end else if (cmd_i.exec && (op == OP_SW)) begin
      mem_we    = 1'b1;
      mem_waddr = mem_addr(addr_sum);
      mem_wdata = c_q[WORD_W-1:0];
    end
    if (cmd_i.decode) begin
      mem_raddr = mem_addr(pc_ext + XLEN'(1));
    end else if (cmd_i.exec) begin
      mem_raddr = mem_addr(addr_sum);
    end
  end

  // Register file port steering
  always_comb begin
    rf_we    = cmd_i.clear;
    rf_waddr = clr_q[RF_AW-1:0];
    rf_wdata = '0;
    if (rf_wr) begin
      rf_we    = 1'b1;
      rf_waddr = rd;
      rf_wdata = res_fin;
    end
    if (cmd_i.decode) begin
      rf_raddr = mem_rdata[7:4];
    end else if (cmd_i.get_rs) begin
      rf_raddr = rt;
    end else if (cmd_i.get_rt) begin
      rf_raddr = rd;
    end else begin
      rf_raddr = rs;
    end
  end

  rie_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rie_ram #(
    .WIDTH (XLEN),
    .DEPTH (NUM_REGS)
  ) u_rf (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      halt_q <= 1'b0;
      cyc_q  <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + MEM_AW'(1);
      end
      if (cmd_i.wb) begin
        pc_q  <= npc_q;
        cyc_q <= cyc_q + XLEN'(cyc_inc);
        if (op == OP_HALT) begin
          halt_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      exec_pc_q <= pc_q;
      ir_q      <= '0;
      wr_q      <= 1'b0;
      widx_q    <= '0;
      wval_q    <= '0;
      unsup_q   <= 1'b0;
    end
    if (cmd_i.decode) begin
      ir_q <= mem_rdata;
    end
    if (cmd_i.get_rs) begin
      imm_q <= imm_d;
      a_q   <= reg_sel(rs, rf_rdata, imm_d);
    end
    if (cmd_i.get_rt) begin
      b_q <= reg_sel(rt, rf_rdata, imm_q);
    end
    if (cmd_i.get_rd) begin
      c_q <= reg_sel(rd, rf_rdata, imm_q);
    end
    if (cmd_i.exec) begin
      res_q <= alu_res;
      npc_q <= pc_wrap(target);
    end
    if (cmd_i.wb) begin
      wr_q    <= rf_wr;
      widx_q  <= rf_wr ? rd : '0;
      wval_q  <= rf_wr ? res_fin : '0;
      unsup_q <= (op inside {[OP_RETI:OP_OUT]});
    end
    if (cmd_i.load_out) begin
      o_exec_pc_q <= exec_pc_q;
      o_iw_q      <= ir_q;
      o_next_pc_q <= pc_q;
      o_halted_q  <= halted_now;
      o_wr_q      <= wr_q;
      o_idx_q     <= widx_q;
      o_val_q     <= wval_q;
      o_cyc_q     <= cyc_q;
      o_unsup_q   <= unsup_q;
    end
  end

  assign exec_pc_o          = o_exec_pc_q;
  assign instruction_word_o = o_iw_q;
  assign next_pc_o          = o_next_pc_q;
  assign halted_o           = o_halted_q;
  assign reg_write_o        = o_wr_q;
  assign reg_index_o        = o_idx_q;
  assign reg_value_o        = o_val_q;
  assign cycle_count_o      = o_cyc_q;
  assign unsupported_o      = o_unsup_q;

endmodule

`default_nettype wire

[rtl/rie_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rie_checker
  import rie_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                action_i,
  input wire logic [LA_W-1:0]     load_address_i,
  input wire logic [WORD_W-1:0]   load_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic [PC_W-1:0]     exec_pc_o,
  input wire logic [WORD_W-1:0]   instruction_word_o,
  input wire logic [PC_W-1:0]     next_pc_o,
  input wire logic                halted_o,
  input wire logic                reg_write_o,
  input wire logic [RF_AW-1:0]    reg_index_o,
  input wire logic [XLEN-1:0]     reg_value_o,
  input wire logic [XLEN-1:0]     cycle_count_o,
  input wire logic                unsupported_o,
  input wire logic                psel,
  input wire logic                penable,
  input wire logic                pwrite,
  input wire logic [APB_AW-1:0]   paddr,
  input wire logic [APB_DW-1:0]   pwdata,
  input wire logic [APB_DW-1:0]   prdata,
  input wire logic                pready
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(exec_pc_o) && $stable(cycle_count_o) && $stable(next_pc_o))
    else $error("result word changed while stalled");

  // One word in flight: ready drops right after an accept.
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in flight");

  // r0 and r1 are never reported as written.
  a_wr_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_write_o |-> reg_index_o != 4'd0 && reg_index_o != 4'd1)
    else $error("write reported to r0 or r1");

  // Without a write, index and value read zero.
  a_no_wr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reg_write_o |-> reg_index_o == 4'd0 && reg_value_o == 32'd0)
    else $error("stale write fields on a word without a write");

  // Unsupported flag only for reti, in, out, and never with a write.
  a_unsup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unsupported_o |->
      !reg_write_o && (instruction_word_o[19:12] == OP_RETI ||
      instruction_word_o[19:12] == OP_IN || instruction_word_o[19:12] == OP_OUT))
    else $error("unsupported flag on a supported opcode");

endmodule

bind risc_instruction_execute rie_checker u_rie_checker (.*);

`default_nettype wire
